@@ hw/rtl/escdt_pkg.sv @@
package escdt_pkg;

    localparam int N_STAGES = 16;

    // secs >>> 7 is offset by a multiple of 675 so the split by 675 runs unsigned
    localparam logic [33:0] SEC_OFFS  = 34'd4294968300;   // 675 * 6362916
    localparam logic [9:0]  D_675     = 10'd675;
    localparam logic [17:0] R_675_LO  = 18'(((64'd1 << 27) + 64'd674) / 64'd675);
    localparam logic [27:0] R_675_HI  = 28'(((64'd1 << 37) + 64'd674) / 64'd675);

    // shifted day count: days + 719468 + 39 eras, kept non-negative
    localparam logic [24:0] DAY_OFFS  = 25'd54335;
    localparam logic [17:0] D_ERA     = 18'd146097;
    localparam logic [24:0] R_ERA     = 25'(((64'd1 << 42) + 64'd146096) / 64'd146097);
    localparam logic [17:0] DOE_LAST  = 18'd146096;
    localparam logic [16:0] YEAR_BASE = 17'd15600;        // 39 eras of 400 years

    localparam logic [11:0] D_3600    = 12'd3600;
    localparam logic [17:0] R_3600    = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
    localparam logic [5:0]  D_60      = 6'd60;
    localparam logic [12:0] R_60      = 13'(((64'd1 << 18) + 64'd59) / 64'd60);

    localparam logic [18:0] R_1460    = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] R_36524   = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [8:0]  D_365     = 9'd365;
    localparam logic [18:0] R_365     = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  R_100     = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [8:0]  D_400     = 9'd400;
    localparam logic [7:0]  D_153     = 8'd153;
    localparam logic [11:0] R_153     = 12'(((64'd1 << 19) + 64'd152) / 64'd153);
    localparam logic [11:0] R_5       = 12'(((64'd1 << 14) + 64'd4) / 64'd5);
    localparam logic [3:0]  MP_JAN    = 4'd10;

endpackage

@@ hw/rtl/epoch_seconds_to_civil_datetime_core.sv @@
// Epoch seconds to civil date and time.
//
// Input channel: epoch_seconds (signed 40-bit seconds since 1970-01-01
// 00:00:00 UTC) with in_valid / in_ready. Output channel: year, month, day,
// hour, minute, second with out_valid / out_ready; one result beat for each
// input beat, in order.
//
// Sixteen register stages; every multiply is by a constant (a reciprocal or
// a divisor) with a register behind it. A beat accepted into stage 0 passes
// through each stage in order to the output registers of stage 15. One beat
// per cycle is accepted for as long as out_ready stays high.
//
// Each stage holds its beat while the stage ahead is full and stalled;
// empty stages keep filling, so in_ready drops only once all sixteen
// stages hold beats and out_ready is low. The output registers hold their
// beat until taken.
//
// Reset clears all stage valid bits; out_valid is low and in_ready high
// coming out of reset.
module epoch_seconds_to_civil_datetime_core
    import escdt_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [39:0] epoch_seconds,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] year,
    output logic [3:0]         month,
    output logic [4:0]         day,
    output logic [4:0]         hour,
    output logic [5:0]         minute,
    output logic [5:0]         second
);

    logic [N_STAGES-1:0] vld_reg;
    logic [N_STAGES-1:0] vld_next;
    logic [N_STAGES:0]   en;

    assign en[N_STAGES] = out_ready;
    for (genvar i = 0; i < N_STAGES; i++)
    begin : g_en
        assign en[i] = ~vld_reg[i] | en[i+1];
    end

    assign vld_next = {vld_reg[N_STAGES-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= (vld_next & en[N_STAGES-1:0]) | (vld_reg & ~en[N_STAGES-1:0]);
        end
    end

    assign in_ready  = en[0];
    assign out_valid = vld_reg[N_STAGES-1];

    // stage 0: seconds split into a /128 part (offset) and a low part
    logic [33:0] s0_u_reg, s0_u_next;
    logic [6:0]  s0_lo_reg;

    assign s0_u_next = {epoch_seconds[39], epoch_seconds[39:7]} + SEC_OFFS;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_u_reg  <= s0_u_next;
            s0_lo_reg <= epoch_seconds[6:0];
        end
    end

    // stage 1: upper digit of u / 675
    logic [34:0] p1;
    logic [7:0]  s1_q1_reg, s1_q1_next;
    logic [33:0] s1_u_reg;
    logic [6:0]  s1_lo_reg;

    assign p1         = 35'(s0_u_reg[33:17]) * 35'(R_675_LO);
    assign s1_q1_next = p1[34:27];

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_q1_reg <= s1_q1_next;
            s1_u_reg  <= s0_u_reg;
            s1_lo_reg <= s0_lo_reg;
        end
    end

    // stage 2: remainder of the upper digit joined with the lower bits
    logic [17:0] p2, r1;
    logic [26:0] s2_x_reg, s2_x_next;
    logic [7:0]  s2_q1_reg;
    logic [6:0]  s2_lo_reg;

    assign p2        = 18'(s1_q1_reg) * 18'(D_675);
    assign r1        = 18'(s1_u_reg[33:17]) - p2;
    assign s2_x_next = {r1[9:0], s1_u_reg[16:0]};

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_x_reg  <= s2_x_next;
            s2_q1_reg <= s1_q1_reg;
            s2_lo_reg <= s1_lo_reg;
        end
    end

    // stage 3: lower digit of u / 675
    logic [54:0] p3;
    logic [16:0] s3_q2_reg, s3_q2_next;
    logic [26:0] s3_x_reg;
    logic [7:0]  s3_q1_reg;
    logic [6:0]  s3_lo_reg;

    assign p3         = 55'(s2_x_reg) * 55'(R_675_HI);
    assign s3_q2_next = p3[53:37];

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_q2_reg <= s3_q2_next;
            s3_x_reg  <= s2_x_reg;
            s3_q1_reg <= s2_q1_reg;
            s3_lo_reg <= s2_lo_reg;
        end
    end

    // stage 4: time of day and shifted day count
    logic [26:0] p4, r2;
    logic [24:0] zsum;
    logic [23:0] s4_zo_reg, s4_zo_next;
    logic [16:0] s4_tod_reg, s4_tod_next;

    assign p4          = 27'(s3_q2_reg) * 27'(D_675);
    assign r2          = s3_x_reg - p4;
    assign s4_tod_next = {r2[9:0], s3_lo_reg};
    assign zsum        = {s3_q1_reg[7:0], s3_q2_reg} + DAY_OFFS;
    assign s4_zo_next  = zsum[23:0];

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_zo_reg  <= s4_zo_next;
            s4_tod_reg <= s4_tod_next;
        end
    end

    // stage 5: era and hour
    logic [48:0] p5e;
    logic [34:0] p5h;
    logic [6:0]  s5_era_reg, s5_era_next;
    logic [4:0]  s5_h_reg, s5_h_next;
    logic [23:0] s5_zo_reg;
    logic [16:0] s5_tod_reg;

    assign p5e         = 49'(s4_zo_reg) * 49'(R_ERA);
    assign s5_era_next = p5e[48:42];
    assign p5h         = 35'(s4_tod_reg) * 35'(R_3600);
    assign s5_h_next   = p5h[33:29];

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_era_reg <= s5_era_next;
            s5_h_reg   <= s5_h_next;
            s5_zo_reg  <= s4_zo_reg;
            s5_tod_reg <= s4_tod_reg;
        end
    end

    // stage 6: day of era and seconds within the hour
    logic [24:0] p6e, doe_w;
    logic [16:0] p6h, rem_w;
    logic [17:0] s6_doe_reg, s6_doe_next;
    logic [11:0] s6_rem_reg, s6_rem_next;
    logic [6:0]  s6_era_reg;
    logic [4:0]  s6_h_reg;

    assign p6e         = 25'(s5_era_reg) * 25'(D_ERA);
    assign doe_w       = 25'(s5_zo_reg) - p6e;
    assign s6_doe_next = doe_w[17:0];
    assign p6h         = 17'(s5_h_reg) * 17'(D_3600);
    assign rem_w       = s5_tod_reg - p6h;
    assign s6_rem_next = rem_w[11:0];

    always_ff @(posedge clk)
    begin
        if (en[6])
        begin
            s6_doe_reg <= s6_doe_next;
            s6_rem_reg <= s6_rem_next;
            s6_era_reg <= s5_era_reg;
            s6_h_reg   <= s5_h_reg;
        end
    end

    // stage 7: leap corrections, minute, era years
    logic [36:0] p7a, p7b;
    logic [24:0] p7m;
    logic [6:0]  s7_a_reg, s7_a_next;
    logic [2:0]  s7_b_reg, s7_b_next;
    logic        s7_c_reg, s7_c_next;
    logic [5:0]  s7_min_reg, s7_min_next;
    logic [15:0] s7_era4_reg, s7_era4_next;
    logic [17:0] s7_doe_reg;
    logic [11:0] s7_rem_reg;
    logic [4:0]  s7_h_reg;

    assign p7a          = 37'(s6_doe_reg) * 37'(R_1460);
    assign s7_a_next    = p7a[35:29];
    assign p7b          = 37'(s6_doe_reg) * 37'(R_36524);
    assign s7_b_next    = p7b[36:34];
    assign s7_c_next    = (s6_doe_reg == DOE_LAST);
    assign p7m          = 25'(s6_rem_reg) * 25'(R_60);
    assign s7_min_next  = p7m[23:18];
    assign s7_era4_next = 16'(s6_era_reg) * 16'(D_400);

    always_ff @(posedge clk)
    begin
        if (en[7])
        begin
            s7_a_reg    <= s7_a_next;
            s7_b_reg    <= s7_b_next;
            s7_c_reg    <= s7_c_next;
            s7_min_reg  <= s7_min_next;
            s7_era4_reg <= s7_era4_next;
            s7_doe_reg  <= s6_doe_reg;
            s7_rem_reg  <= s6_rem_reg;
            s7_h_reg    <= s6_h_reg;
        end
    end

    // stage 8: leap-adjusted day count, second
    logic [11:0] p8s, sec_w;
    logic [17:0] s8_t_reg, s8_t_next;
    logic [5:0]  s8_sec_reg, s8_sec_next;
    logic [17:0] s8_doe_reg;
    logic [15:0] s8_era4_reg;
    logic [4:0]  s8_h_reg;
    logic [5:0]  s8_min_reg;

    assign s8_t_next   = s7_doe_reg - 18'(s7_a_reg) + 18'(s7_b_reg) - 18'(s7_c_reg);
    assign p8s         = 12'(s7_min_reg) * 12'(D_60);
    assign sec_w       = s7_rem_reg - p8s;
    assign s8_sec_next = sec_w[5:0];

    always_ff @(posedge clk)
    begin
        if (en[8])
        begin
            s8_t_reg    <= s8_t_next;
            s8_sec_reg  <= s8_sec_next;
            s8_doe_reg  <= s7_doe_reg;
            s8_era4_reg <= s7_era4_reg;
            s8_h_reg    <= s7_h_reg;
            s8_min_reg  <= s7_min_reg;
        end
    end

    // stage 9: year of era
    logic [36:0] p9;
    logic [8:0]  s9_yoe_reg, s9_yoe_next;
    logic [17:0] s9_doe_reg;
    logic [15:0] s9_era4_reg;
    logic [4:0]  s9_h_reg;
    logic [5:0]  s9_min_reg, s9_sec_reg;

    assign p9          = 37'(s8_t_reg) * 37'(R_365);
    assign s9_yoe_next = p9[35:27];

    always_ff @(posedge clk)
    begin
        if (en[9])
        begin
            s9_yoe_reg  <= s9_yoe_next;
            s9_doe_reg  <= s8_doe_reg;
            s9_era4_reg <= s8_era4_reg;
            s9_h_reg    <= s8_h_reg;
            s9_min_reg  <= s8_min_reg;
            s9_sec_reg  <= s8_sec_reg;
        end
    end

    // stage 10: days before the year of era
    logic [18:0] p10c;
    logic [17:0] s10_y365_reg, s10_y365_next;
    logic [2:0]  s10_y100_reg, s10_y100_next;
    logic [8:0]  s10_yoe_reg;
    logic [17:0] s10_doe_reg;
    logic [15:0] s10_era4_reg;
    logic [4:0]  s10_h_reg;
    logic [5:0]  s10_min_reg, s10_sec_reg;

    assign s10_y365_next = 18'(s9_yoe_reg) * 18'(D_365);
    assign p10c          = 19'(s9_yoe_reg) * 19'(R_100);
    assign s10_y100_next = p10c[18:16];

    always_ff @(posedge clk)
    begin
        if (en[10])
        begin
            s10_y365_reg <= s10_y365_next;
            s10_y100_reg <= s10_y100_next;
            s10_yoe_reg  <= s9_yoe_reg;
            s10_doe_reg  <= s9_doe_reg;
            s10_era4_reg <= s9_era4_reg;
            s10_h_reg    <= s9_h_reg;
            s10_min_reg  <= s9_min_reg;
            s10_sec_reg  <= s9_sec_reg;
        end
    end

    // stage 11: day of year, March based
    logic [17:0] doy_w;
    logic [8:0]  s11_doy_reg, s11_doy_next;
    logic [8:0]  s11_yoe_reg;
    logic [15:0] s11_era4_reg;
    logic [4:0]  s11_h_reg;
    logic [5:0]  s11_min_reg, s11_sec_reg;

    assign doy_w = s10_doe_reg
                 - (s10_y365_reg + 18'(s10_yoe_reg[8:2]) - 18'(s10_y100_reg));
    assign s11_doy_next = doy_w[8:0];

    always_ff @(posedge clk)
    begin
        if (en[11])
        begin
            s11_doy_reg  <= s11_doy_next;
            s11_yoe_reg  <= s10_yoe_reg;
            s11_era4_reg <= s10_era4_reg;
            s11_h_reg    <= s10_h_reg;
            s11_min_reg  <= s10_min_reg;
            s11_sec_reg  <= s10_sec_reg;
        end
    end

    // stage 12: March-based month
    logic [10:0] w12;
    logic [22:0] p12;
    logic [3:0]  s12_mp_reg, s12_mp_next;
    logic [8:0]  s12_doy_reg, s12_yoe_reg;
    logic [15:0] s12_era4_reg;
    logic [4:0]  s12_h_reg;
    logic [5:0]  s12_min_reg, s12_sec_reg;

    assign w12         = {s11_doy_reg, 2'b00} + 11'(s11_doy_reg) + 11'd2;
    assign p12         = 23'(w12) * 23'(R_153);
    assign s12_mp_next = p12[22:19];

    always_ff @(posedge clk)
    begin
        if (en[12])
        begin
            s12_mp_reg   <= s12_mp_next;
            s12_doy_reg  <= s11_doy_reg;
            s12_yoe_reg  <= s11_yoe_reg;
            s12_era4_reg <= s11_era4_reg;
            s12_h_reg    <= s11_h_reg;
            s12_min_reg  <= s11_min_reg;
            s12_sec_reg  <= s11_sec_reg;
        end
    end

    // stage 13: 153 * mp + 2
    logic [11:0] p13;
    logic [10:0] s13_v_reg, s13_v_next;
    logic [3:0]  s13_mp_reg;
    logic [8:0]  s13_doy_reg, s13_yoe_reg;
    logic [15:0] s13_era4_reg;
    logic [4:0]  s13_h_reg;
    logic [5:0]  s13_min_reg, s13_sec_reg;

    assign p13        = 12'(s12_mp_reg) * 12'(D_153) + 12'd2;
    assign s13_v_next = p13[10:0];

    always_ff @(posedge clk)
    begin
        if (en[13])
        begin
            s13_v_reg    <= s13_v_next;
            s13_mp_reg   <= s12_mp_reg;
            s13_doy_reg  <= s12_doy_reg;
            s13_yoe_reg  <= s12_yoe_reg;
            s13_era4_reg <= s12_era4_reg;
            s13_h_reg    <= s12_h_reg;
            s13_min_reg  <= s12_min_reg;
            s13_sec_reg  <= s12_sec_reg;
        end
    end

    // stage 14: days before the month
    logic [22:0] p14;
    logic [8:0]  s14_d5_reg, s14_d5_next;
    logic [3:0]  s14_mp_reg;
    logic [8:0]  s14_doy_reg, s14_yoe_reg;
    logic [15:0] s14_era4_reg;
    logic [4:0]  s14_h_reg;
    logic [5:0]  s14_min_reg, s14_sec_reg;

    assign p14         = 23'(s13_v_reg) * 23'(R_5);
    assign s14_d5_next = p14[22:14];

    always_ff @(posedge clk)
    begin
        if (en[14])
        begin
            s14_d5_reg   <= s14_d5_next;
            s14_mp_reg   <= s13_mp_reg;
            s14_doy_reg  <= s13_doy_reg;
            s14_yoe_reg  <= s13_yoe_reg;
            s14_era4_reg <= s13_era4_reg;
            s14_h_reg    <= s13_h_reg;
            s14_min_reg  <= s13_min_reg;
            s14_sec_reg  <= s13_sec_reg;
        end
    end

    // stage 15: output registers
    logic [8:0]  day_w;
    logic [16:0] year_w;
    logic        jan_feb;
    logic [15:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;
    logic [4:0]  day_reg, day_next;
    logic [4:0]  hour_reg;
    logic [5:0]  minute_reg, second_reg;

    assign jan_feb    = (s14_mp_reg >= MP_JAN);
    assign day_w      = s14_doy_reg - s14_d5_reg + 9'd1;
    assign day_next   = day_w[4:0];
    assign month_next = jan_feb ? (s14_mp_reg - 4'd9) : (s14_mp_reg + 4'd3);
    assign year_w     = 17'(s14_era4_reg) + 17'(s14_yoe_reg) - YEAR_BASE + 17'(jan_feb);
    assign year_next  = year_w[15:0];

    always_ff @(posedge clk)
    begin
        if (en[15])
        begin
            year_reg   <= year_next;
            month_reg  <= month_next;
            day_reg    <= day_next;
            hour_reg   <= s14_h_reg;
            minute_reg <= s14_min_reg;
            second_reg <= s14_sec_reg;
        end
    end

    assign year   = year_reg;
    assign month  = month_reg;
    assign day    = day_reg;
    assign hour   = hour_reg;
    assign minute = minute_reg;
    assign second = second_reg;

endmodule

@@ hw/rtl/escdt_checker.sv @@
module escdt_checker
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic signed [39:0] epoch_seconds,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [15:0] year,
    input logic [3:0]         month,
    input logic [4:0]         day,
    input logic [4:0]         hour,
    input logic [5:0]         minute,
    input logic [5:0]         second
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid
            && $stable({year, month, day, hour, minute, second}))
        else $error("result beat changed while stalled");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> month >= 4'd1 && month <= 4'd12 && day >= 5'd1
            && hour <= 5'd23 && minute <= 6'd59 && second <= 6'd59)
        else $error("result field out of range");

    a_month_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (month != 4'd2 || day <= 5'd29)
            && (day != 5'd31 || (month != 4'd4 && month != 4'd6
                && month != 4'd9 && month != 4'd11)))
        else $error("day beyond end of month");

    a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_ready |-> in_ready)
        else $error("input stalled while sink ready");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result beat during reset");

endmodule

bind epoch_seconds_to_civil_datetime_core escdt_checker u_escdt_checker (.*);
